[sv/cdc_pkg.sv]
// ----------------------------------------------------------------------------
// cdc_pkg: calendar date counter shared types and constants
// Command and result beat layouts, command and status codes, month lengths.
// ----------------------------------------------------------------------------
package cdc_pkg;

	localparam logic [1:0] CMD_ADVANCE  = 2'd0;
	localparam logic [1:0] CMD_LOAD_MDY = 2'd1;
	localparam logic [1:0] CMD_LOAD_DOY = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_INVALID  = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [13:0] YEAR_MAX         = 14'd9999;
	localparam logic [13:0] YEAR_RESET       = 14'd2000;
	localparam logic [13:0] YEAR_FLOOR_RESET = 14'd1900;
	localparam logic [3:0]  MONTH_MAX        = 4'd12;
	localparam logic [4:0]  LEAP_FEB_LEN     = 5'd29;
	localparam logic [8:0]  YEAR_DAYS        = 9'd365;
	localparam logic [8:0]  LEAP_YEAR_DAYS   = 9'd366;

	// floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT, exact for y < 43690
	localparam logic [12:0] RECIP_25    = 13'd5243;
	localparam int          RECIP_SHIFT = 17;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [8:0]  day_of_year_in;
		logic [13:0] year_in;
	} cdc_cmd_t;

	typedef struct packed {
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [13:0] year_out;
		logic [1:0]  status;
	} cdc_res_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                        len = leap ? LEAP_FEB_LEN : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

[sv/cdc_core.sv]
// ----------------------------------------------------------------------------
// cdc_core: date state and command sequencer
// Leap test by reciprocal multiply, then one compare/subtract per cycle for
// the day-of-year month walk.
// ----------------------------------------------------------------------------
module cdc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [13:0]       year_floor,
	input  logic              start,
	input  cdc_pkg::cdc_cmd_t cmd,
	output logic              ready,
	input  logic              out_free,
	output logic              done,
	output cdc_pkg::cdc_res_t res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_CHK,
		S_WALK,
		S_DONE
	} state_t;

	localparam logic [13:0] RECIP_25_EXT = {1'b0, cdc_pkg::RECIP_25};

	state_t            state_q;
	cdc_pkg::cdc_cmd_t cmd_q;
	logic [13:0]       yr_q;
	logic [9:0]        quot_q;
	logic              leap_q;
	logic [3:0]        mm_q;
	logic [8:0]        rest_q;
	logic [3:0]        cur_month_q;
	logic [4:0]        cur_day_q;
	logic [13:0]       cur_year_q;
	logic [1:0]        status_q;

	logic [26:0] prod;
	logic [14:0] times25;
	logic        div25;
	logic        leap;
	logic        year_ok;
	logic [4:0]  cur_len;
	logic [4:0]  mdy_len;
	logic [8:0]  total;
	logic [4:0]  walk_len;
	logic        walk_gt;
	logic [8:0]  walk_diff;

	assign prod    = yr_q * RECIP_25_EXT;
	assign times25 = {1'b0, quot_q, 4'b0} + {2'b0, quot_q, 3'b0} + {5'b0, quot_q};
	assign div25   = (times25 == {1'b0, yr_q});
	assign leap    = (yr_q[1:0] == 2'b00) && (!div25 || (yr_q[3:0] == 4'b0000));
	assign year_ok = (cmd_q.year_in >= year_floor) && (cmd_q.year_in <= cdc_pkg::YEAR_MAX);
	assign cur_len = cdc_pkg::month_len(cur_month_q, leap);
	assign mdy_len = cdc_pkg::month_len(cmd_q.month_in, leap);
	assign total   = leap ? cdc_pkg::LEAP_YEAR_DAYS : cdc_pkg::YEAR_DAYS;

	// shared compare/subtract for the month walk
	assign walk_len  = cdc_pkg::month_len(mm_q, leap_q);
	assign walk_gt   = rest_q > {4'b0, walk_len};
	assign walk_diff = rest_q - {4'b0, walk_len};

	assign ready = (state_q == S_IDLE);
	assign done  = (state_q == S_DONE) && out_free;
	assign res   = '{month_out: cur_month_q, day_out: cur_day_q,
	                 year_out: cur_year_q, status: status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_month_q <= 4'd1;
			cur_day_q   <= 5'd1;
			cur_year_q  <= cdc_pkg::YEAR_RESET;
			status_q    <= cdc_pkg::STATUS_OK;
			cmd_q       <= '0;
			yr_q        <= '0;
			quot_q      <= '0;
			leap_q      <= 1'b0;
			mm_q        <= 4'd1;
			rest_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						yr_q    <= (cmd.command == cdc_pkg::CMD_ADVANCE) ? cur_year_q
						                                                 : cmd.year_in;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					quot_q  <= prod[cdc_pkg::RECIP_SHIFT +: 10];
					state_q <= S_CHK;
				end
				S_CHK: begin
					leap_q   <= leap;
					status_q <= cdc_pkg::STATUS_OK;
					state_q  <= S_DONE;
					case (cmd_q.command)
						cdc_pkg::CMD_ADVANCE: begin
							if ({1'b0, cur_day_q} + 6'd1 > {1'b0, cur_len}) begin
								if (cur_month_q >= cdc_pkg::MONTH_MAX) begin
									if (cur_year_q >= cdc_pkg::YEAR_MAX) begin
										status_q <= cdc_pkg::STATUS_OVERFLOW;
									end else begin
										cur_day_q   <= 5'd1;
										cur_month_q <= 4'd1;
										cur_year_q  <= cur_year_q + 14'd1;
									end
								end else begin
									cur_day_q   <= 5'd1;
									cur_month_q <= cur_month_q + 4'd1;
								end
							end else begin
								cur_day_q <= cur_day_q + 5'd1;
							end
						end
						cdc_pkg::CMD_LOAD_MDY: begin
							if (year_ok && cmd_q.month_in >= 4'd1 &&
							    cmd_q.month_in <= cdc_pkg::MONTH_MAX &&
							    cmd_q.day_in >= 5'd1 && cmd_q.day_in <= mdy_len) begin
								cur_month_q <= cmd_q.month_in;
								cur_day_q   <= cmd_q.day_in;
								cur_year_q  <= cmd_q.year_in;
							end else begin
								status_q <= cdc_pkg::STATUS_INVALID;
							end
						end
						cdc_pkg::CMD_LOAD_DOY: begin
							if (year_ok && cmd_q.day_of_year_in >= 9'd1 &&
							    cmd_q.day_of_year_in <= total) begin
								mm_q    <= 4'd1;
								rest_q  <= cmd_q.day_of_year_in;
								state_q <= S_WALK;
							end else begin
								status_q <= cdc_pkg::STATUS_INVALID;
							end
						end
						default: begin
						end
					endcase
				end
				S_WALK: begin
					if (mm_q < cdc_pkg::MONTH_MAX && walk_gt) begin
						rest_q <= walk_diff;
						mm_q   <= mm_q + 4'd1;
					end else begin
						cur_month_q <= mm_q;
						cur_day_q   <= rest_q[4:0];
						cur_year_q  <= cmd_q.year_in;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_month: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.month_out >= 4'd1) && (res.month_out <= cdc_pkg::MONTH_MAX))
		else $error("result month out of range");

	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_day_q != 5'd0)
		else $error("stored day is zero");

	a_walk_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (rest_q != 9'd0) && (mm_q <= cdc_pkg::MONTH_MAX))
		else $error("month walk out of range");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle");

	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start && ready) |=> (state_q == S_DIV))
		else $error("accepted beat did not start the leap test");

endmodule

[sv/calendar_date_counter.sv]
// ----------------------------------------------------------------------------
// calendar_date_counter: Gregorian month/day/year counter
// Advances one day or loads a checked date; result beat per command.
// ----------------------------------------------------------------------------
// Sequence: an accepted beat goes through the leap test, the checks and, for a
//   day-of-year load, the month walk, then its result is registered at output.
// Throughput: one beat at a time; a stalled result holds the sequencer and input.
// Reset: date 1/1/2000, year floor 1900, no result pending.
module calendar_date_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [13:0]       cfg_wdata,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cdc_pkg::cdc_cmd_t cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output cdc_pkg::cdc_res_t res
);

	logic              core_ready;
	logic              core_done;
	logic              out_free;
	cdc_pkg::cdc_res_t core_res;
	logic [13:0]       year_floor_q;
	logic              res_valid_q;
	cdc_pkg::cdc_res_t res_q;

	assign cmd_stall = !core_ready;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	cdc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.year_floor (year_floor_q),
		.start      (cmd_valid),
		.cmd        (cmd),
		.ready      (core_ready),
		.out_free   (out_free),
		.done       (core_done),
		.res        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_floor_q <= cdc_pkg::YEAR_FLOOR_RESET;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				year_floor_q <= cfg_wdata;
			end
			if (core_done) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			res_q <= core_res;
		end
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: calendar_date_counter self-checking bench
// Sends advance, load and unused commands with random gaps while the result side
// stalls at random. A scoreboard class tracks the expected date and status
// for each accepted command and checks every result beat field by field.
// The year floor is changed between phases, including 0, 9999 and out of range.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int PHASE_ITEMS    = 160;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AT_RESULT = 150;

	class date_scoreboard;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [13:0]       year;
		logic [13:0]       year_floor;
		cdc_pkg::cdc_res_t pending_dates[$];
		int errors, n_checked, n_advance, n_load_mdy, n_load_doy, n_unused;
		int n_invalid, n_overflow, n_year_floor;

		function new();
			month      = 4'd1;
			day        = 5'd1;
			year       = cdc_pkg::YEAR_RESET;
			year_floor = cdc_pkg::YEAR_FLOOR_RESET;
		endfunction

		function bit is_leap(int y);
			return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
		endfunction

		function int days_in_month(int m, int y);
			case (m)
				1, 3, 5, 7, 8, 10, 12: return 31;
				4, 6, 9, 11:           return 30;
				2:                     return is_leap(y) ? 29 : 28;
				default:               return 0;
			endcase
		endfunction

		function void note_command(cdc_pkg::cdc_cmd_t c);
			cdc_pkg::cdc_res_t want;
			logic [1:0]        st;
			bit                year_ok;
			int                total, mm, rest;
			st      = cdc_pkg::STATUS_OK;
			year_ok = c.year_in >= year_floor && c.year_in <= cdc_pkg::YEAR_MAX;
			case (c.command)
				cdc_pkg::CMD_ADVANCE: begin
					n_advance++;
					if (int'(day) + 1 > days_in_month(month, year)) begin
						if (month >= cdc_pkg::MONTH_MAX) begin
							if (year >= cdc_pkg::YEAR_MAX) begin
								st = cdc_pkg::STATUS_OVERFLOW;
							end else begin
								day   = 5'd1;
								month = 4'd1;
								year  = year + 14'd1;
							end
						end else begin
							day   = 5'd1;
							month = month + 4'd1;
						end
					end else begin
						day = day + 5'd1;
					end
				end
				cdc_pkg::CMD_LOAD_MDY: begin
					n_load_mdy++;
					if (year_ok && c.month_in >= 1 && c.month_in <= cdc_pkg::MONTH_MAX
							&& c.day_in >= 1
							&& c.day_in <= days_in_month(c.month_in, c.year_in)) begin
						month = c.month_in;
						day   = c.day_in;
						year  = c.year_in;
					end else begin
						st = cdc_pkg::STATUS_INVALID;
					end
				end
				cdc_pkg::CMD_LOAD_DOY: begin
					n_load_doy++;
					total = is_leap(c.year_in) ? cdc_pkg::LEAP_YEAR_DAYS : cdc_pkg::YEAR_DAYS;
					if (year_ok && c.day_of_year_in >= 1 && c.day_of_year_in <= total) begin
						mm   = 1;
						rest = c.day_of_year_in;
						while (mm < cdc_pkg::MONTH_MAX
								&& rest > days_in_month(mm, c.year_in)) begin
							rest -= days_in_month(mm, c.year_in);
							mm++;
						end
						month = 4'(mm);
						day   = 5'(rest);
						year  = c.year_in;
					end else begin
						st = cdc_pkg::STATUS_INVALID;
					end
				end
				default: begin
					n_unused++;
				end
			endcase
			if (st == cdc_pkg::STATUS_INVALID) n_invalid++;
			if (st == cdc_pkg::STATUS_OVERFLOW) n_overflow++;
			want.month_out = month;
			want.day_out   = day;
			want.year_out  = year;
			want.status    = st;
			pending_dates.push_back(want);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(cdc_pkg::cdc_res_t got);
			cdc_pkg::cdc_res_t want;
			if (pending_dates.size() == 0) begin
				$display("%0t: stray result, expected none, actual %0d/%0d/%0d st %0d",
					$time, got.month_out, got.day_out, got.year_out, got.status);
				errors++;
				return;
			end
			want = pending_dates.pop_front();
			n_checked++;
			compare_field("month_out", want.month_out, got.month_out);
			compare_field("day_out", want.day_out, got.day_out);
			compare_field("year_out", want.year_out, got.year_out);
			compare_field("status", want.status, got.status);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [13:0]       cfg_wdata;
	logic              cmd_valid;
	logic              cmd_stall;
	cdc_pkg::cdc_cmd_t cmd;
	logic              res_valid;
	logic              res_stall;
	cdc_pkg::cdc_res_t res;

	date_scoreboard sb;

	calendar_date_counter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("%0t: timeout with %0d results outstanding", $time, sb.pending_dates.size());
		$display("** calendar_date_counter: FAILED **");
		$finish;
	end

	// result side: random stalls, plus one long hold to back up the block
	initial begin : result_sink
		int  stall_left, free_left, hold_left, r;
		bit  hold_done;
		stall_left = 0;
		free_left  = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		res_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) sb.check_result(res);
			if (!hold_done && sb.n_checked >= HOLD_AT_RESULT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (stall_left == 0 && free_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 50) free_left = $urandom_range(1, 8);
				else if (r < 60) free_left = $urandom_range(30, 100);
				else if (r < 85) stall_left = $urandom_range(1, 3);
				else if (r < 97) stall_left = $urandom_range(4, 15);
				else stall_left = $urandom_range(20, 60);
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				free_left--;
				res_stall <= 1'b0;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic cdc_pkg::cdc_cmd_t rand_cmd();
		cdc_pkg::cdc_cmd_t c;
		c.command        = 2'($urandom);
		c.month_in       = 4'($urandom);
		c.day_in         = 5'($urandom);
		c.day_of_year_in = 9'($urandom);
		c.year_in        = 14'($urandom);
		return c;
	endfunction

	function automatic logic [13:0] pick_year();
		int lo, r, y;
		lo = sb.year_floor;
		r  = $urandom_range(0, 99);
		if (lo > int'(cdc_pkg::YEAR_MAX) || r < 10) return 14'($urandom);
		if (r < 25) return 14'($urandom_range(int'(cdc_pkg::YEAR_MAX), (lo > 9990) ? lo : 9990));
		if (r < 40) y = 100 * $urandom_range(0, 99);
		else if (r < 55) y = 4 * $urandom_range(0, 2499);
		else if (r < 63) y = lo;
		else if (r < 68) y = (lo > 0) ? lo - 1 : 0;
		else y = $urandom_range(lo, int'(cdc_pkg::YEAR_MAX));
		if (y < lo && r < 63) y = lo;
		return 14'(y);
	endfunction

	task automatic send_cmd(input cdc_pkg::cdc_cmd_t c);
		int gap;
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_command(c);
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [1:0] op, input int m, input int d, input int doy,
			input int y);
		cdc_pkg::cdc_cmd_t c;
		c                = rand_cmd();
		c.command        = op;
		c.month_in       = 4'(m);
		c.day_in         = 5'(d);
		c.day_of_year_in = 9'(doy);
		c.year_in        = 14'(y);
		send_cmd(c);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (sb.pending_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_year_floor(input logic [13:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.year_floor = v;
		sb.n_year_floor++;
	endtask

	task automatic run_directed();
		issue(cdc_pkg::CMD_ADVANCE, 15, 31, 511, 16383);
		issue(cdc_pkg::CMD_LOAD_MDY, 2, 29, 0, 2000);
		issue(cdc_pkg::CMD_ADVANCE, 0, 0, 0, 0);
		issue(cdc_pkg::CMD_LOAD_MDY, 2, 29, 0, 1900);
		issue(cdc_pkg::CMD_LOAD_MDY, 2, 29, 0, 2004);
		issue(cdc_pkg::CMD_LOAD_MDY, 2, 29, 0, 2001);
		issue(cdc_pkg::CMD_LOAD_MDY, 2, 28, 0, 2001);
		issue(cdc_pkg::CMD_ADVANCE, 0, 0, 0, 0);
		issue(cdc_pkg::CMD_LOAD_MDY, 12, 31, 0, 9999);
		issue(cdc_pkg::CMD_ADVANCE, 0, 0, 0, 0);
		issue(cdc_pkg::CMD_LOAD_MDY, 1, 1, 0, 1899);
		issue(cdc_pkg::CMD_LOAD_MDY, 1, 1, 0, 1900);
		issue(cdc_pkg::CMD_LOAD_MDY, 0, 1, 0, 2000);
		issue(cdc_pkg::CMD_LOAD_MDY, 13, 1, 0, 2000);
		issue(cdc_pkg::CMD_LOAD_MDY, 15, 1, 0, 2000);
		issue(cdc_pkg::CMD_LOAD_MDY, 1, 0, 0, 2000);
		issue(cdc_pkg::CMD_LOAD_MDY, 4, 31, 0, 2000);
		issue(cdc_pkg::CMD_LOAD_MDY, 1, 31, 0, 2000);
		issue(cdc_pkg::CMD_LOAD_MDY, 1, 1, 0, 10000);
		issue(cdc_pkg::CMD_LOAD_MDY, 15, 31, 511, 16383);
		issue(cdc_pkg::CMD_LOAD_DOY, 0, 0, 0, 2000);
		issue(cdc_pkg::CMD_LOAD_DOY, 0, 0, 366, 2001);
		issue(cdc_pkg::CMD_LOAD_DOY, 0, 0, 366, 2000);
		issue(cdc_pkg::CMD_LOAD_DOY, 0, 0, 60, 2004);
		issue(cdc_pkg::CMD_LOAD_DOY, 0, 0, 511, 2004);
		issue(cdc_pkg::CMD_LOAD_DOY, 0, 0, 1, 1900);
		issue(CMD_UNUSED, 6, 15, 100, 2010);
		issue(cdc_pkg::CMD_LOAD_MDY, 12, 31, 0, 1999);
		issue(cdc_pkg::CMD_ADVANCE, 0, 0, 0, 0);
	endtask

	// mostly a load followed by a run of advances, some raw noise
	task automatic run_phase(input int n);
		int                done, kind, r, steps, len, total;
		cdc_pkg::cdc_cmd_t c;
		done = 0;
		while (done < n) begin
			kind = $urandom_range(0, 99);
			c    = rand_cmd();
			if (kind < 8) begin
				send_cmd(c);
				if (c.command != CMD_UNUSED) done++;
				continue;
			end
			c.year_in = pick_year();
			if (kind < 45) begin
				c.command  = cdc_pkg::CMD_LOAD_MDY;
				r          = $urandom_range(0, 99);
				c.month_in = (r < 90) ? 4'($urandom_range(1, 12)) : 4'($urandom);
				len        = sb.days_in_month(c.month_in, c.year_in);
				r          = $urandom_range(0, 99);
				if (len == 0) c.day_in = 5'($urandom);
				else if (r < 40) c.day_in = 5'(len);
				else if (r < 50) c.day_in = 5'(len + 1);
				else c.day_in = 5'($urandom_range(1, len));
			end else if (kind < 75) begin
				c.command = cdc_pkg::CMD_LOAD_DOY;
				total     = sb.is_leap(c.year_in) ? 366 : 365;
				r         = $urandom_range(0, 99);
				if (r < 30) c.day_of_year_in = 9'($urandom_range(total - 30, total));
				else if (r < 40) c.day_of_year_in = 9'(total + 1);
				else if (r < 45) c.day_of_year_in = 9'($urandom);
				else if (r < 50) c.day_of_year_in = 9'd0;
				else c.day_of_year_in = 9'($urandom_range(1, total));
			end else begin
				c.command  = cdc_pkg::CMD_LOAD_MDY;
				r          = $urandom_range(0, 2);
				c.month_in = (r == 0) ? 4'd2 : (r == 1) ? 4'd12 : 4'($urandom_range(1, 12));
				if (r == 1 && $urandom_range(0, 1) == 1) c.year_in = cdc_pkg::YEAR_MAX;
				len      = sb.days_in_month(c.month_in, c.year_in);
				c.day_in = 5'($urandom_range(len - 2, len));
			end
			send_cmd(c);
			done++;
			steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
			repeat (steps) begin
				c         = rand_cmd();
				c.command = cdc_pkg::CMD_ADVANCE;
				send_cmd(c);
				done++;
			end
		end
	endtask

	initial begin
		logic [13:0] year_floors[5];
		sb        = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		cmd_valid = 1'b0;
		cmd       = '0;
		year_floors = '{14'd0, cdc_pkg::YEAR_MAX, 14'h3FFF, 14'($urandom_range(1, 9998)),
			cdc_pkg::YEAR_FLOOR_RESET};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		foreach (year_floors[i]) begin
			write_year_floor(year_floors[i]);
			run_phase(PHASE_ITEMS);
		end
		wait_idle();
		$display("Checked %0d results: %0d advance, %0d m/d/y load, %0d doy load, %0d unused.",
			sb.n_checked, sb.n_advance, sb.n_load_mdy, sb.n_load_doy, sb.n_unused);
		$display("Saw %0d rejected loads and %0d year overflows over %0d year floor settings.",
			sb.n_invalid, sb.n_overflow, sb.n_year_floor + 1);
		if (sb.errors == 0) begin
			$display("** calendar_date_counter: PASSED **");
		end else begin
			$display("** calendar_date_counter: FAILED **");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/cdc_pkg.sv
sv/cdc_core.sv
sv/calendar_date_counter.sv
tb/testbench.sv
